FILE: hw/rtl/btnode_pkg.sv
// ----------------------------------------------------------------------------
// btnode_pkg: shared types and codes for the B+ tree internal node engine
// Opcodes, status codes, field widths and the per-cell update control.
// ----------------------------------------------------------------------------
`default_nettype none

package btnode_pkg;

  // Field widths that do not follow from the node parameters
  localparam int unsigned OP_W   = 4;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CFG_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP     = 4'd0;
  localparam logic [OP_W-1:0] OP_FIND_CHILD = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd3;
  localparam logic [OP_W-1:0] OP_POPULATE   = 4'd4;
  localparam logic [OP_W-1:0] OP_TAKE_ONLY  = 4'd5;
  localparam logic [OP_W-1:0] OP_READ       = 4'd6;
  localparam logic [OP_W-1:0] OP_WR_KEY     = 4'd7;
  localparam logic [OP_W-1:0] OP_WR_CHILD   = 4'd8;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOCHILD = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

  // Where a cell takes its next key or child from
  typedef enum logic [2:0] {
    SRC_HOLD,
    SRC_LOWER,
    SRC_UPPER,
    SRC_IN_A,
    SRC_IN_B
  } src_e;

  typedef struct packed {
    src_e key_src;
    src_e child_src;
  } cell_act_t;

  typedef struct packed {
    logic ge_en;
    logic eq_en;
  } cell_cmp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/btnode_cell.sv
// ----------------------------------------------------------------------------
// btnode_cell: one entry of the node
// Holds one separator key and child id, shifts with its neighbors and
// registers the compare flags used by lookup and child search.
// ----------------------------------------------------------------------------
`default_nettype none

module btnode_cell import btnode_pkg::*; #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned CHILD_BITS = 32
) (
  input  wire                           clk_i,
  input  var cell_act_t                 act_i,
  input  var cell_cmp_t                 cmp_i,
  input  wire logic signed [KEY_BITS-1:0]   in_key_i,
  input  wire logic signed [CHILD_BITS-1:0] in_child_i,
  input  wire logic signed [CHILD_BITS-1:0] in_newc_i,
  input  wire logic signed [KEY_BITS-1:0]   lower_key_i,
  input  wire logic signed [CHILD_BITS-1:0] lower_child_i,
  input  wire logic signed [KEY_BITS-1:0]   upper_key_i,
  input  wire logic signed [CHILD_BITS-1:0] upper_child_i,
  output logic signed [KEY_BITS-1:0]        key_o,
  output logic signed [CHILD_BITS-1:0]      child_o,
  output logic                              ge_o,
  output logic                              eq_o
);

  logic signed [KEY_BITS-1:0]   key_q, key_d;
  logic signed [CHILD_BITS-1:0] child_q, child_d;
  logic                         ge_q, eq_q;

  always_comb begin
    case (act_i.key_src)
      SRC_LOWER: key_d = lower_key_i;
      SRC_UPPER: key_d = upper_key_i;
      SRC_IN_A:  key_d = in_key_i;
      default:   key_d = key_q;
    endcase
    case (act_i.child_src)
      SRC_LOWER: child_d = lower_child_i;
      SRC_UPPER: child_d = upper_child_i;
      SRC_IN_A:  child_d = in_child_i;
      SRC_IN_B:  child_d = in_newc_i;
      default:   child_d = child_q;
    endcase
  end

  // Flags: search key not below this key, and child id match
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    child_q <= child_d;
    ge_q    <= cmp_i.ge_en && !(in_key_i < key_q);
    eq_q    <= cmp_i.eq_en && (in_child_i == child_q);
  end

  assign key_o   = key_q;
  assign child_o = child_q;
  assign ge_o    = ge_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

FILE: hw/rtl/btree_internal_node_engine.sv
// ----------------------------------------------------------------------------
// btree_internal_node_engine: one B+ tree internal node in a row of cells
// Lookup, child search, insert after a child, remove, root populate, take
// only child, single entry read and write, and clear, one item per operation.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | op, clear_node, search_key,
//          |           |                           | child_id, new_child_id, slot
//  out     | output    | out_valid_o / out_stall_i | child_out, key_out, slot_out,
//          |           |                           | size_out, status
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (max_entries)
//
//  An item is accepted in the idle state, its per-cell compare flags are
//  registered in EVAL and the cells and output register are updated in EXEC;
//  a new item is taken only once the state is back in idle.
//  A stalled output holds its result; the next item waits in its last cycle.
//  Reset empties the node and sets max_entries to the smaller of MAX_SLOTS
//  and 64; entry contents are not cleared and read back undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module btree_internal_node_engine import btnode_pkg::*; #(
  parameter int unsigned MAX_SLOTS  = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned CHILD_BITS = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input items
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [OP_W-1:0]              op_i,
  input  wire                               clear_node_i,
  input  wire logic signed [KEY_BITS-1:0]   search_key_i,
  input  wire logic signed [CHILD_BITS-1:0] child_id_i,
  input  wire logic signed [CHILD_BITS-1:0] new_child_id_i,
  input  wire logic [SLOT_W-1:0]            slot_i,
  // result items
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [CHILD_BITS-1:0]      child_out_o,
  output logic signed [KEY_BITS-1:0]        key_out_o,
  output logic [SLOT_W-1:0]                 slot_out_o,
  output logic [SIZE_W-1:0]                 size_out_o,
  output logic [ST_W-1:0]                   status_o,
  // configuration
  input  wire                               cfg_we_i,
  input  wire logic [CFG_W-1:0]             cfg_wdata_i
);

  localparam int unsigned IDXW = $clog2(MAX_SLOTS);
  localparam int unsigned CNTW = $clog2(MAX_SLOTS + 1);
  // common width for index, count and slot compares
  localparam int unsigned WW   = (CNTW > SLOT_W) ? CNTW : SLOT_W;
  localparam int unsigned LW   = (CNTW > CFG_W) ? CNTW : CFG_W;
  localparam int unsigned LIM_RST = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  // held item
  logic [OP_W-1:0]              op_q;
  logic                         clr_q;
  logic signed [KEY_BITS-1:0]   key_q;
  logic signed [CHILD_BITS-1:0] child_q;
  logic signed [CHILD_BITS-1:0] newc_q;
  logic [SLOT_W-1:0]            slot_q;

  logic [CNTW-1:0] count_q, count_d;
  logic [LW-1:0]   lim_q, lim_d;

  logic in_acc, fire;

  // cell row
  logic signed [KEY_BITS-1:0]   cell_key   [MAX_SLOTS];
  logic signed [CHILD_BITS-1:0] cell_child [MAX_SLOTS];
  logic signed [KEY_BITS-1:0]   key_m      [MAX_SLOTS];
  logic signed [CHILD_BITS-1:0] child_m    [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]         ge_vec, eq_vec;

  // encoded search results
  logic [IDXW-1:0] lk_idx, fd_idx;
  logic            fd_hit;
  logic [WW-1:0]   cnt_w, s_w, p_w, rd_w;
  logic            slot_ok, full, ins_ok;

  logic signed [KEY_BITS-1:0]   rd_key;
  logic signed [CHILD_BITS-1:0] rd_child;

  // output register
  logic                         out_valid_q;
  logic signed [CHILD_BITS-1:0] child_out_q, child_out_d;
  logic signed [KEY_BITS-1:0]   key_out_q, key_out_d;
  logic [SLOT_W-1:0]            slot_out_q, slot_out_d;
  logic [SIZE_W-1:0]            size_out_q;
  logic [ST_W-1:0]              status_q, status_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  // Advance one step per cycle; wait in IDLE for an item and in EXEC while the output holds a stalled result
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EVAL;
      S_EVAL:  state_d = S_EXEC;
      S_EXEC:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      clr_q   <= clear_node_i;
      key_q   <= search_key_i;
      child_q <= child_id_i;
      newc_q  <= new_child_id_i;
      slot_q  <= slot_i;
    end
  end

  // Clamp max_entries into 2..MAX_SLOTS when it is written
  always_comb begin
    lim_d = LW'(cfg_wdata_i);
    if (lim_d < LW'(2)) begin
      lim_d = LW'(2);
    end else if (lim_d > LW'(MAX_SLOTS)) begin
      lim_d = LW'(MAX_SLOTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LW'(LIM_RST);
    end else if (cfg_we_i) begin
      lim_q <= lim_d;
    end
  end

  // Encode the registered flags: highest key hit, lowest child hit
  always_comb begin
    lk_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (ge_vec[i]) lk_idx = IDXW'(i);
    end
    fd_idx = '0;
    fd_hit = 1'b0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (eq_vec[i]) begin
        fd_idx = IDXW'(i);
        fd_hit = 1'b1;
      end
    end
  end

  assign cnt_w   = WW'(count_q);
  assign s_w     = WW'(slot_q);
  assign p_w     = WW'(fd_idx) + WW'(1);
  assign slot_ok = (s_w < cnt_w);
  assign full    = (LW'(count_q) >= lim_q);
  assign ins_ok  = fd_hit && !full;

  // Entry to read back: lookup choice, addressed slot, or slot zero
  always_comb begin
    case (op_q)
      OP_LOOKUP: rd_w = WW'(lk_idx);
      OP_READ:   rd_w = s_w;
      default:   rd_w = '0;
    endcase
  end

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    localparam logic [WW-1:0] I  = WW'(i);
    localparam logic [WW-1:0] I1 = WW'(i + 1);

    cell_act_t act;
    cell_cmp_t cmp;
    logic signed [KEY_BITS-1:0]   lo_key, up_key;
    logic signed [CHILD_BITS-1:0] lo_child, up_child;

    if (i == 0) begin : g_lo_end
      assign lo_key   = cell_key[i];
      assign lo_child = cell_child[i];
    end else begin : g_lo
      assign lo_key   = cell_key[i-1];
      assign lo_child = cell_child[i-1];
    end

    if (i == MAX_SLOTS - 1) begin : g_up_end
      assign up_key   = cell_key[i];
      assign up_child = cell_child[i];
    end else begin : g_up
      assign up_key   = cell_key[i+1];
      assign up_child = cell_child[i+1];
    end

    assign cmp.ge_en = (i >= 1) && (I < cnt_w);
    assign cmp.eq_en = (I < cnt_w);

    // Per-cell update: hold unless this item moves or writes the entry
    always_comb begin
      act.key_src   = SRC_HOLD;
      act.child_src = SRC_HOLD;
      if (fire && !clr_q) begin
        case (op_q)
          OP_INSERT: begin
            if (ins_ok) begin
              if (I == p_w) begin
                act.key_src   = SRC_IN_A;
                act.child_src = SRC_IN_B;
              end else if (I > p_w && I <= cnt_w) begin
                act.key_src   = SRC_LOWER;
                act.child_src = SRC_LOWER;
              end
            end
          end
          OP_REMOVE: begin
            if (slot_ok && I >= s_w && I1 < cnt_w) begin
              act.key_src   = SRC_UPPER;
              act.child_src = SRC_UPPER;
            end
          end
          OP_POPULATE: begin
            if (i == 0) begin
              act.child_src = SRC_IN_A;
            end else if (i == 1) begin
              act.key_src   = SRC_IN_A;
              act.child_src = SRC_IN_B;
            end
          end
          OP_WR_KEY: begin
            if (slot_ok && I == s_w) act.key_src = SRC_IN_A;
          end
          OP_WR_CHILD: begin
            if (slot_ok && I == s_w) act.child_src = SRC_IN_A;
          end
          default: ;
        endcase
      end
    end

    btnode_cell #(
      .KEY_BITS  (KEY_BITS),
      .CHILD_BITS(CHILD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .act_i        (act),
      .cmp_i        (cmp),
      .in_key_i     (key_q),
      .in_child_i   (child_q),
      .in_newc_i    (newc_q),
      .lower_key_i  (lo_key),
      .lower_child_i(lo_child),
      .upper_key_i  (up_key),
      .upper_child_i(up_child),
      .key_o        (cell_key[i]),
      .child_o      (cell_child[i]),
      .ge_o         (ge_vec[i]),
      .eq_o         (eq_vec[i])
    );

    // Mask all but the selected entry for the AND-OR readout
    assign key_m[i]   = (I == rd_w) ? cell_key[i] : '0;
    assign child_m[i] = (I == rd_w) ? cell_child[i] : '0;
  end

  always_comb begin
    rd_key   = '0;
    rd_child = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rd_key   = rd_key | key_m[i];
      rd_child = rd_child | child_m[i];
    end
  end

  // Result and new entry count for the held item
  always_comb begin
    count_d     = count_q;
    child_out_d = '0;
    key_out_d   = '0;
    slot_out_d  = '0;
    status_d    = ST_OK;
    if (clr_q) begin
      count_d = '0;
    end else begin
      case (op_q)
        OP_LOOKUP: begin
          if (count_q == '0) begin
            status_d = ST_RANGE;
          end else begin
            slot_out_d  = SLOT_W'(lk_idx);
            child_out_d = rd_child;
          end
        end
        OP_FIND_CHILD: begin
          if (fd_hit) slot_out_d = SLOT_W'(fd_idx);
          else status_d = ST_NOCHILD;
        end
        OP_INSERT: begin
          if (!fd_hit) begin
            status_d = ST_NOCHILD;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d    = count_q + CNTW'(1);
            slot_out_d = SLOT_W'(p_w);
          end
        end
        OP_REMOVE: begin
          if (slot_ok) count_d = count_q - CNTW'(1);
          else status_d = ST_RANGE;
        end
        OP_POPULATE: begin
          count_d = CNTW'(2);
        end
        OP_TAKE_ONLY: begin
          if (count_q == '0) begin
            status_d = ST_RANGE;
          end else begin
            child_out_d = rd_child;
            count_d     = '0;
          end
        end
        OP_READ: begin
          if (slot_ok) begin
            child_out_d = rd_child;
            key_out_d   = rd_key;
          end else begin
            status_d = ST_RANGE;
          end
        end
        OP_WR_KEY, OP_WR_CHILD: begin
          if (!slot_ok) status_d = ST_RANGE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      child_out_q <= child_out_d;
      key_out_q   <= key_out_d;
      slot_out_q  <= slot_out_d;
      status_q    <= status_d;
      size_out_q  <= SIZE_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign child_out_o = child_out_q;
  assign key_out_o   = key_out_q;
  assign slot_out_o  = slot_out_q;
  assign size_out_o  = size_out_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

FILE: verif/tb_btree_internal_node_engine.sv
// ----------------------------------------------------------------------------
// tb_btree_internal_node_engine: self-checking bench for the B+ tree node
// Runs a short table of directed operations from reset, then phases of
// random operations under several node limits and idle patterns. A local
// shadow of the node predicts the result items of all but the typed rows, and
// each result item is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_btree_internal_node_engine import btnode_pkg::*;;

  localparam int unsigned NODE_SLOTS = 64;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned CHILD_W    = 32;

  localparam logic [KEY_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] WORD_MAX = 32'h7fff_ffff;

  // Opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 94;
  localparam int unsigned DRAIN_WAIT = 4;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               clr;
    logic [KEY_W-1:0]   key;
    logic [CHILD_W-1:0] child;
    logic [CHILD_W-1:0] newc;
    logic [SLOT_W-1:0]  slot;
  } node_req_t;

  typedef struct packed {
    logic [CHILD_W-1:0] child;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
    logic [SIZE_W-1:0]  size;
    logic [ST_W-1:0]    status;
  } node_ans_t;

  // ROW_TYPED rows carry their answer in the table, ROW_CHECK rows go to the
  // shadow node, ROW_CFG rows rewrite the node limit (value in the key column)
  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_CHECK,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    node_req_t         req;
    logic [SIZE_W-1:0] size;
    logic [ST_W-1:0]   status;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals, the inputs all known from time zero
  // --------------------------------------------------------------------------
  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic [OP_W-1:0]           op_i           = '0;
  logic                      clear_node_i   = 1'b0;
  logic signed [KEY_W-1:0]   search_key_i   = '0;
  logic signed [CHILD_W-1:0] child_id_i     = '0;
  logic signed [CHILD_W-1:0] new_child_id_i = '0;
  logic [SLOT_W-1:0]         slot_i         = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic signed [CHILD_W-1:0] child_out_o;
  logic signed [KEY_W-1:0]   key_out_o;
  logic [SLOT_W-1:0]         slot_out_o;
  logic [SIZE_W-1:0]         size_out_o;
  logic [ST_W-1:0]           status_o;
  logic                      cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata_i    = '0;

  btree_internal_node_engine #(
    .MAX_SLOTS  (NODE_SLOTS),
    .KEY_BITS   (KEY_W),
    .CHILD_BITS (CHILD_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .clear_node_i   (clear_node_i),
    .search_key_i   (search_key_i),
    .child_id_i     (child_id_i),
    .new_child_id_i (new_child_id_i),
    .slot_i         (slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .child_out_o    (child_out_o),
    .key_out_o      (key_out_o),
    .slot_out_o     (slot_out_o),
    .size_out_o     (size_out_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow node: keys, children, entry count and the node limit register.
  // key_known marks key cells that hold a written value; children below the
  // count are always written, but slot 0's key is not set by populate_root.
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0]   node_keys     [NODE_SLOTS];
  logic [CHILD_W-1:0] node_children [NODE_SLOTS];
  logic               key_known     [NODE_SLOTS];
  int                 node_count = 0;
  logic [CFG_W-1:0]   node_limit = 7'd64;

  node_ans_t node_answers [$];
  dir_row_t  dir_rows [$];
  int        fault_count    = 0;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;

  initial begin
    for (int i = 0; i < NODE_SLOTS; i++) begin
      node_keys[i]     = '0;
      node_children[i] = '0;
      key_known[i]     = 1'b0;
    end
  end

  // Lowest slot below the count holding the child, or -1
  function automatic int child_slot(input logic [CHILD_W-1:0] child);
    int pos;
    pos = -1;
    for (int i = node_count - 1; i >= 0; i--)
      if (node_children[i] == child) pos = i;
    return pos;
  endfunction

  // Apply one item to the shadow node and return the result item it causes
  function automatic node_ans_t compute_node_answer(input node_req_t r);
    node_ans_t a;
    int        hit;
    int        lim;
    int        s;
    int        i;
    a = '0;
    s = r.slot;
    if (r.clr) begin
      node_count = 0;
    end else begin
      case (r.op)
        OP_LOOKUP: begin
          if (node_count == 0) begin
            a.status = ST_RANGE;
          end else begin
            // scan down from the top: first key not above the search key wins
            hit = 0;
            for (i = node_count - 1; i >= 1 && hit == 0; i--)
              if (!($signed(r.key) < $signed(node_keys[i]))) hit = i;
            a.slot  = SLOT_W'(hit);
            a.child = node_children[hit];
          end
        end
        OP_FIND_CHILD: begin
          hit = child_slot(r.child);
          if (hit < 0) a.status = ST_NOCHILD;
          else a.slot = SLOT_W'(hit);
        end
        OP_INSERT: begin
          hit = child_slot(r.child);
          lim = (node_limit < 2) ? 2 : (node_limit > NODE_SLOTS) ? NODE_SLOTS : node_limit;
          if (hit < 0) begin
            a.status = ST_NOCHILD;
          end else if (node_count >= lim) begin
            a.status = ST_FULL;
          end else begin
            for (i = node_count; i > hit + 1; i--) begin
              node_keys[i]     = node_keys[i-1];
              node_children[i] = node_children[i-1];
              key_known[i]     = key_known[i-1];
            end
            node_keys[hit+1]     = r.key;
            node_children[hit+1] = r.newc;
            key_known[hit+1]     = 1'b1;
            node_count++;
            a.slot = SLOT_W'(hit + 1);
          end
        end
        OP_REMOVE: begin
          if (s >= node_count) begin
            a.status = ST_RANGE;
          end else begin
            for (i = s; i + 1 < node_count; i++) begin
              node_keys[i]     = node_keys[i+1];
              node_children[i] = node_children[i+1];
              key_known[i]     = key_known[i+1];
            end
            node_count--;
          end
        end
        OP_POPULATE: begin
          node_children[0] = r.child;
          node_keys[1]     = r.key;
          node_children[1] = r.newc;
          key_known[1]     = 1'b1;
          node_count       = 2;
        end
        OP_TAKE_ONLY: begin
          if (node_count == 0) begin
            a.status = ST_RANGE;
          end else begin
            // extra entries are dropped along with the only child
            a.child    = node_children[0];
            node_count = 0;
          end
        end
        OP_READ: begin
          if (s >= node_count) begin
            a.status = ST_RANGE;
          end else begin
            a.child = node_children[s];
            a.key   = node_keys[s];
          end
        end
        OP_WR_KEY: begin
          if (s >= node_count) begin
            a.status = ST_RANGE;
          end else begin
            node_keys[s] = r.key;
            key_known[s] = 1'b1;
          end
        end
        OP_WR_CHILD: begin
          if (s >= node_count) a.status = ST_RANGE;
          else node_children[s] = r.child;
        end
        default: begin
        end
      endcase
    end
    a.size = SIZE_W'(node_count);
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] draw_word();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      4:       return KEY_W'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed operations aimed at live entries, plus some noise
  function automatic node_req_t draw_request();
    node_req_t   r;
    int unsigned dice;
    int unsigned pos;
    logic        aim;
    r.op    = OP_LOOKUP;
    r.clr   = 1'b0;
    r.key   = draw_word();
    r.child = draw_word();
    r.newc  = draw_word();
    r.slot  = SLOT_W'($urandom_range(NODE_SLOTS - 1));
    dice    = $urandom_range(99);
    aim     = ($urandom_range(9) != 0) && (node_count != 0);
    pos     = (node_count == 0) ? 0 : $urandom_range(node_count - 1);
    if (node_count == 0 && dice < 60) begin
      r.op = OP_POPULATE;
    end else if (dice < 20) begin
      r.op = OP_LOOKUP;
      if (aim && pos != 0) begin
        // land on, just below or just above a separator
        case ($urandom_range(2))
          0:       r.key = node_keys[pos] - 1;
          1:       r.key = node_keys[pos];
          default: r.key = node_keys[pos] + 1;
        endcase
      end
    end else if (dice < 30) begin
      r.op = OP_FIND_CHILD;
      if (aim) r.child = node_children[pos];
    end else if (dice < 55) begin
      r.op = OP_INSERT;
      if (aim) r.child = node_children[pos];
    end else if (dice < 65) begin
      r.op = OP_REMOVE;
      if (aim) r.slot = SLOT_W'(pos);
    end else if (dice < 75) begin
      r.op = OP_READ;
      if (aim) r.slot = SLOT_W'(pos);
    end else if (dice < 81) begin
      r.op = OP_WR_KEY;
      if (aim) r.slot = SLOT_W'(pos);
    end else if (dice < 87) begin
      r.op = OP_WR_CHILD;
      if (aim) r.slot = SLOT_W'(pos);
    end else if (dice < 90) begin
      r.op = OP_TAKE_ONLY;
    end else if (dice < 93) begin
      r.op = OP_POPULATE;
    end else if (dice < 96) begin
      r.clr = 1'b1;
      r.op  = OP_W'($urandom_range(OP_SPARE_HI));
    end else begin
      r.op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    end
    // never read back a key cell that holds no written value: write it instead
    if (!r.clr && r.op == OP_READ && r.slot < node_count && !key_known[r.slot])
      r.op = OP_WR_KEY;
    return r;
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [OP_W-1:0] op, input logic clr,
                         input logic [KEY_W-1:0] key, input logic [CHILD_W-1:0] child,
                         input logic [CHILD_W-1:0] newc, input int slot, input int size,
                         input logic [ST_W-1:0] status);
    dir_row_t d;
    d.kind      = kind;
    d.req.op    = op;
    d.req.clr   = clr;
    d.req.key   = key;
    d.req.child = child;
    d.req.newc  = newc;
    d.req.slot  = SLOT_W'(slot);
    d.size      = SIZE_W'(size);
    d.status    = status;
    dir_rows.push_back(d);
  endtask

  // Offer one item, hold it until accepted, then record its result item.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic push_item(input node_req_t r, input logic typed, input node_ans_t fixed);
    node_ans_t a;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= r.op;
    clear_node_i   <= r.clr;
    search_key_i   <= r.key;
    child_id_i     <= r.child;
    new_child_id_i <= r.newc;
    slot_i         <= r.slot;
    do @(posedge clk_i); while (in_stall_o);
    a = compute_node_answer(r);
    node_answers.push_back(typed ? fixed : a);
  endtask

  // Drop valid, wait for every result item, then let the pipe run dry
  task automatic settle();
    in_valid_i <= 1'b0;
    while (node_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    node_limit = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at the rate of the current phase
  // --------------------------------------------------------------------------
  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result item with the oldest one due
  // --------------------------------------------------------------------------
  node_ans_t due;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (node_answers.size() == 0) begin
        $error("result item with nothing pending: status %0d size %0d", status_o, size_out_o);
        fault_count++;
      end else begin
        due = node_answers.pop_front();
        if (child_out_o !== due.child) begin
          $error("child_out: expected %0d, got %0d", $signed(due.child), child_out_o);
          fault_count++;
        end
        if (key_out_o !== due.key) begin
          $error("key_out: expected %0d, got %0d", $signed(due.key), key_out_o);
          fault_count++;
        end
        if (slot_out_o !== due.slot) begin
          $error("slot_out: expected %0d, got %0d", due.slot, slot_out_o);
          fault_count++;
        end
        if (size_out_o !== due.size) begin
          $error("size_out: expected %0d, got %0d", due.size, size_out_o);
          fault_count++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status_o);
          fault_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] limits [PHASES];

    // Empty node after reset: every access is refused
    add_row(ROW_TYPED, OP_LOOKUP,     0, 0, 0, 0, 0,  0, ST_RANGE);
    add_row(ROW_TYPED, OP_TAKE_ONLY,  0, 0, 0, 0, 0,  0, ST_RANGE);
    add_row(ROW_TYPED, OP_REMOVE,     0, 0, 0, 0, 0,  0, ST_RANGE);
    add_row(ROW_TYPED, OP_READ,       0, 0, 0, 0, 63, 0, ST_RANGE);
    add_row(ROW_TYPED, OP_FIND_CHILD, 0, 0, 1, 0, 0,  0, ST_NOCHILD);
    add_row(ROW_TYPED, OP_INSERT,     0, 5, 1, 2, 0,  0, ST_NOCHILD);
    // Two-entry root with extreme children, then lookups at the key extremes and at the separator
    add_row(ROW_TYPED, OP_POPULATE, 0, 0, WORD_MIN, WORD_MAX, 0, 2, ST_OK);
    add_row(ROW_CHECK, OP_LOOKUP,   0, WORD_MIN, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_LOOKUP,   0, 0,        0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_LOOKUP,   0, WORD_MAX, 0, 0, 0, 0, ST_OK);
    // Append at the top, insert in the middle with a duplicate child
    add_row(ROW_CHECK, OP_INSERT,      0, 100,       WORD_MAX, 7, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_INSERT,      0, -32'sd100, WORD_MIN, 7, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_FIND_CHILD,  0, 0,         7,        0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_INSERT,      0, -32'sd50,  7,        9, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_WR_KEY,      0, WORD_MIN,  0,        0, 2, 0, ST_OK);
    add_row(ROW_CHECK, OP_WR_CHILD,    0, 0,         '1,       0, 4, 0, ST_OK);
    add_row(ROW_CHECK, OP_WR_CHILD,    0, 0,         3,        0, 5, 0, ST_OK);
    // Removing slot 0 pulls a written key into slot 0, so it may be read
    add_row(ROW_CHECK, OP_REMOVE,      0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_READ,        0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_SPARE_HI,    0, WORD_MAX, WORD_MAX, WORD_MAX, 63, 0, ST_OK);
    add_row(ROW_CHECK, OP_REMOVE,      0, 0, 0, 0, 3, 0, ST_OK);
    // Limit of three on a three-entry node: full, but unknown child wins
    add_row(ROW_CFG,   OP_LOOKUP,      0, 3, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_INSERT,      0, 1, 9,     5, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_INSERT,      0, 1, 12345, 5, 0, 0, ST_OK);
    // Shrink to one entry, look it up, take it
    add_row(ROW_CHECK, OP_REMOVE,      0, 0, 0, 0, 1, 0, ST_OK);
    add_row(ROW_CHECK, OP_REMOVE,      0, 0, 0, 0, 1, 0, ST_OK);
    add_row(ROW_CHECK, OP_LOOKUP,      0, WORD_MAX, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_TAKE_ONLY,   0, 0, 0, 0, 0, 0, ST_OK);
    // Take the only child of a two-entry node; clear a populated node
    add_row(ROW_CHECK, OP_POPULATE,    0, 10, 1, 2, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_TAKE_ONLY,   0, 0,  0, 0, 0, 0, ST_OK);
    add_row(ROW_CHECK, OP_POPULATE,    0, 20, 3, 4, 0, 0, ST_OK);
    add_row(ROW_TYPED, OP_LOOKUP,      1, 0,  0, 0, 0, 0, ST_OK);

    // Node limits per random phase: in-range, both clamps and every bit set
    limits[0] = 7'd2;
    limits[1] = 7'd0;
    limits[2] = 7'd127;
    limits[3] = 7'd3;
    limits[4] = CFG_W'($urandom_range(63, 3));
    limits[5] = 7'd1;
    limits[6] = 7'd64;
    limits[7] = 7'd17;

    // Hold reset, then release it on an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with no idling on either side
    foreach (dir_rows[n]) begin
      case (dir_rows[n].kind)
        ROW_CFG: begin
          settle();
          write_limit(dir_rows[n].req.key[CFG_W-1:0]);
        end
        ROW_TYPED: push_item(dir_rows[n].req, 1'b1,
                             '{child: '0, key: '0, slot: '0,
                               size: dir_rows[n].size, status: dir_rows[n].status});
        default:   push_item(dir_rows[n].req, 1'b0, '0);
      endcase
    end

    // Random phases: rewrite the limit while idle, then vary the idling
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_limit(limits[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++)
        push_item(draw_request(), 1'b0, '0);
    end

    // Drain the last result items and close the run
    settle();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/btnode_pkg.sv
hw/rtl/btnode_cell.sv
hw/rtl/btree_internal_node_engine.sv
verif/tb_btree_internal_node_engine.sv
